// ===== rtl/skps_pkg.sv =====
// skps_pkg: shared types, constants and tables of the keyword scanner
// holds the classified byte struct and the modern-feature word list
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package skps_pkg;

  // scan window and word sizes
  localparam int unsigned SCAN_WINDOW  = 256;
  localparam int unsigned POS_W        = $clog2(SCAN_WINDOW + 1);
  localparam int unsigned MAX_WORD_LEN = 23;
  localparam int unsigned RUN_W        = $clog2(MAX_WORD_LEN + 2);
  localparam int unsigned NUM_WORDS    = 31;
  localparam int unsigned WIDX_W       = $clog2(NUM_WORDS);
  localparam int unsigned WORD_BITS    = MAX_WORD_LEN * 8;

  // version parsing
  localparam int unsigned VER_W          = 17;
  localparam int unsigned VERSION_LIMIT  = 9999;
  localparam int unsigned MODERN_MIN_VER = 450;

  // marker text, first character in the top byte
  localparam int unsigned MARKER_LEN = 8;
  localparam int unsigned MPROG_W    = $clog2(MARKER_LEN);
  localparam logic [MARKER_LEN*8-1:0] MARKER_TEXT = "#version";

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // word list, right justified: last character in the low byte
  localparam logic [WORD_BITS-1:0] WORD_TEXT [NUM_WORDS] = '{
    WORD_BITS'("buffer"), WORD_BITS'("std430"),
    WORD_BITS'("image1D"), WORD_BITS'("image2D"), WORD_BITS'("image3D"),
    WORD_BITS'("imageCube"), WORD_BITS'("image2DRect"), WORD_BITS'("image1DArray"),
    WORD_BITS'("image2DArray"), WORD_BITS'("imageCubeArray"),
    WORD_BITS'("imageBuffer"), WORD_BITS'("iimage1D"), WORD_BITS'("iimage2D"),
    WORD_BITS'("iimage3D"), WORD_BITS'("iimageCube"),
    WORD_BITS'("uimage1D"), WORD_BITS'("uimage2D"), WORD_BITS'("uimage3D"),
    WORD_BITS'("uimageCube"), WORD_BITS'("image2DMS"), WORD_BITS'("image2DMSArray"),
    WORD_BITS'("imageLoad"), WORD_BITS'("imageStore"),
    WORD_BITS'("subgroup"), WORD_BITS'({"gl_", "Subgroup"}),
    WORD_BITS'({"gl_", "SUBGROUP_SIZE"}),
    WORD_BITS'("int64_t"), WORD_BITS'({"u", "int64_t"}),
    WORD_BITS'({"GL_ARB_gpu_", "shader_int64"}),
    WORD_BITS'("shared"), WORD_BITS'({"local_", "size_x"})
  };

  localparam logic [RUN_W-1:0] WORD_LEN [NUM_WORDS] = '{
    RUN_W'(6),  RUN_W'(6),
    RUN_W'(7),  RUN_W'(7),  RUN_W'(7),  RUN_W'(9),
    RUN_W'(11), RUN_W'(12), RUN_W'(12), RUN_W'(14),
    RUN_W'(11), RUN_W'(8),  RUN_W'(8),  RUN_W'(8),  RUN_W'(10),
    RUN_W'(8),  RUN_W'(8),  RUN_W'(8),  RUN_W'(10),
    RUN_W'(9),  RUN_W'(14),
    RUN_W'(9),  RUN_W'(10),
    RUN_W'(8),  RUN_W'(11), RUN_W'(16),
    RUN_W'(7),  RUN_W'(8),  RUN_W'(23),
    RUN_W'(6),  RUN_W'(12)
  };

  // classified source byte, carried from front to back
  typedef struct packed {
    logic [7:0]            data;
    logic                  present;
    logic                  last;
    logic                  compute;
    logic                  ident;
    logic                  digit;
    logic                  blank;
    logic [MARKER_LEN-1:0] marker_hit;  // bit k: byte equals marker character k
  } item_t;

  // character r of word w, valid only when r is below the word length
  function automatic logic [7:0] word_char(input logic [WIDX_W-1:0] w,
                                           input logic [RUN_W-1:0]  r);
    logic [RUN_W-1:0]     sel;
    logic [WORD_BITS-1:0] sh;
    sel = WORD_LEN[w] - RUN_W'(1) - r;
    sh  = WORD_TEXT[w] >> {sel, 3'b000};
    return sh[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/shader_profile_keyword_scanner_unit.sv =====
// shader_profile_keyword_scanner_unit: top level of the keyword scanner
// depends on skps_pkg, skps_front, skps_queue, skps_back
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | data_byte, byte_present, last_byte, is_compute
//   out     | output    | out_valid_o/out_stall_i | profile, glsl_version, feature_seen
//
// one source byte per cycle when neither side stalls; the back stage updates all scan state
// and all 31 word matchers for each byte
// the last byte passes the front holding register and the queue before the result register
// a four entry queue lets the input keep flowing while the result is held
// reset is asynchronous and clears control state; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module shader_profile_keyword_scanner_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [7:0]                data_byte_i,
  input  wire logic                      byte_present_i,
  input  wire logic                      last_byte_i,
  input  wire logic                      is_compute_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           profile_o,
  output logic [skps_pkg::VER_W-1:0]     glsl_version_o,
  output logic                           feature_seen_o
);

  logic            q_full;
  logic            push;
  skps_pkg::item_t push_item;
  logic            pop;
  logic            head_vld;
  skps_pkg::item_t head_item;

  // byte intake and classification
  skps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .is_compute_i   (is_compute_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  // decoupling queue
  skps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_vld_o  (head_vld),
    .head_item_o (head_item)
  );

  // scanning and result
  skps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_vld_i     (head_vld),
    .head_item_i    (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .profile_o      (profile_o),
    .glsl_version_o (glsl_version_o),
    .feature_seen_o (feature_seen_o)
  );

endmodule

`default_nettype wire

// ===== rtl/skps_front.sv =====
// skps_front: input stage, registers each byte and classifies it
// depends on skps_pkg
`timescale 1ns / 1ps
`default_nettype none

module skps_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           byte_present_i,
  input  wire logic           last_byte_i,
  input  wire logic           is_compute_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output skps_pkg::item_t     push_item_o
);

  logic            vld_q, vld_d;
  skps_pkg::item_t item_q, item_d;
  logic            accept;

  // stall only while the held item cannot move on
  assign in_stall_o = vld_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = vld_q & ~q_full_i;
  assign push_item_o = item_q;

  // byte classification
  always_comb begin
    item_d         = item_q;
    item_d.data    = data_byte_i;
    item_d.present = byte_present_i;
    item_d.last    = last_byte_i;
    item_d.compute = is_compute_i;
    item_d.ident   = (data_byte_i >= "a" && data_byte_i <= "z") ||
                     (data_byte_i >= "A" && data_byte_i <= "Z") ||
                     (data_byte_i >= "0" && data_byte_i <= "9") ||
                     (data_byte_i == skps_pkg::CH_UNDER);
    item_d.digit   = (data_byte_i >= "0" && data_byte_i <= "9");
    item_d.blank   = (data_byte_i == skps_pkg::CH_SPACE) ||
                     (data_byte_i == skps_pkg::CH_TAB);
    for (int k = 0; k < skps_pkg::MARKER_LEN; k++) begin
      item_d.marker_hit[k] =
        (data_byte_i == skps_pkg::MARKER_TEXT[(skps_pkg::MARKER_LEN-1-k)*8 +: 8]);
    end
  end

  // holding register valid
  assign vld_d = accept | (vld_q & q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload loads on accept only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/skps_queue.sv =====
// skps_queue: short queue of classified bytes between front and back
// depends on skps_pkg
`timescale 1ns / 1ps
`default_nettype none

module skps_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire skps_pkg::item_t push_item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 head_vld_o,
  output skps_pkg::item_t      head_item_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  skps_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o      = (cnt_q == CNT_W'(DEPTH));
  assign head_vld_o  = (cnt_q != '0);
  assign head_item_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/skps_back.sv =====
// skps_back: scanner state, version parse, word matching and result register
// depends on skps_pkg
`timescale 1ns / 1ps
`default_nettype none

module skps_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          head_vld_i,
  input  wire skps_pkg::item_t               head_item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               profile_o,
  output logic [skps_pkg::VER_W-1:0]         glsl_version_o,
  output logic                               feature_seen_o
);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_BLANK,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  localparam logic [skps_pkg::NUM_WORDS-1:0] ALL_WORDS = '1;

  logic [skps_pkg::POS_W-1:0]     pos_q, pos_d;
  logic                           prev_q, prev_d;
  logic [skps_pkg::MPROG_W-1:0]   mprog_q, mprog_d;
  phase_e                         phase_q, phase_d;
  logic [skps_pkg::VER_W-1:0]     ver_q, ver_d;
  logic [skps_pkg::RUN_W-1:0]     run_q, run_d;
  logic [skps_pkg::NUM_WORDS-1:0] alive_q, alive_d;
  logic                           flag_q, flag_d;

  logic                           out_vld_q, out_vld_d;
  logic                           out_prof_q, out_prof_d;
  logic [skps_pkg::VER_W-1:0]     out_ver_q, out_ver_d;
  logic                           out_feat_q, out_feat_d;

  logic [skps_pkg::NUM_WORDS-1:0] cur_match;
  logic [skps_pkg::NUM_WORDS-1:0] len_eq_cur;
  logic [skps_pkg::NUM_WORDS-1:0] len_eq_nxt;
  logic                           close_cur;
  logic                           close_nxt;
  logic                           flag_fin;
  logic [skps_pkg::VER_W-1:0]     ver_x10;
  logic [skps_pkg::VER_W-1:0]     dig;
  skps_pkg::item_t                it;

  assign it = head_item_i;

  // a last item needs the result register free or draining
  assign pop_o = head_vld_i & (~it.last | ~out_vld_q | ~out_stall_i);

  // per-word prefix test on the current run position
  always_comb begin
    for (int w = 0; w < skps_pkg::NUM_WORDS; w++) begin
      cur_match[w] = (run_q < skps_pkg::RUN_W'(skps_pkg::MAX_WORD_LEN)) &&
                     (run_q < skps_pkg::WORD_LEN[w]) &&
                     (skps_pkg::word_char(skps_pkg::WIDX_W'(w), run_q) == it.data);
      len_eq_cur[w] = (skps_pkg::WORD_LEN[w] == run_q);
    end
  end

  // length test on the updated run, for the close at end of source
  always_comb begin
    for (int w = 0; w < skps_pkg::NUM_WORDS; w++) begin
      len_eq_nxt[w] = (skps_pkg::WORD_LEN[w] == run_d);
    end
  end

  // whole-word hit when a run closes
  assign close_cur = (run_q != '0) && |(alive_q & len_eq_cur);
  assign close_nxt = (run_d != '0) && |(alive_d & len_eq_nxt);
  assign flag_fin  = flag_d | close_nxt;

  assign ver_x10 = (ver_q << 3) + (ver_q << 1);
  assign dig     = skps_pkg::VER_W'(it.data[3:0]);

  // scan of one present byte
  always_comb begin
    pos_d   = pos_q;
    prev_d  = prev_q;
    mprog_d = mprog_q;
    phase_d = phase_q;
    ver_d   = ver_q;
    run_d   = run_q;
    alive_d = alive_q;
    flag_d  = flag_q;
    if (head_vld_i && it.present) begin
      // marker search and version parse
      case (phase_q)
        PH_SEARCH: begin
          if (pos_q < skps_pkg::POS_W'(skps_pkg::SCAN_WINDOW)) begin
            if (mprog_q != '0 && it.marker_hit[mprog_q]) begin
              if (mprog_q == skps_pkg::MPROG_W'(skps_pkg::MARKER_LEN - 1)) begin
                phase_d = PH_BLANK;
                mprog_d = '0;
              end else begin
                mprog_d = mprog_q + skps_pkg::MPROG_W'(1);
              end
            end else if (it.marker_hit[0] && !prev_q) begin
              mprog_d = skps_pkg::MPROG_W'(1);
            end else begin
              mprog_d = '0;
            end
          end
        end
        PH_BLANK: begin
          if (it.blank) begin
            phase_d = PH_BLANK;
          end else if (it.digit) begin
            ver_d   = dig;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (it.digit) begin
            ver_d = ver_x10 + dig;
            if (ver_d > skps_pkg::VER_W'(skps_pkg::VERSION_LIMIT)) begin
              phase_d = PH_DONE;
            end
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
      // identifier runs
      if (it.ident) begin
        alive_d = alive_q & cur_match;
        run_d   = (run_q < skps_pkg::RUN_W'(skps_pkg::MAX_WORD_LEN)) ?
                  run_q + skps_pkg::RUN_W'(1) :
                  skps_pkg::RUN_W'(skps_pkg::MAX_WORD_LEN + 1);
      end else begin
        flag_d  = flag_q | close_cur;
        run_d   = '0;
        alive_d = ALL_WORDS;
      end
      prev_d = it.ident;
      pos_d  = (pos_q < skps_pkg::POS_W'(skps_pkg::SCAN_WINDOW)) ?
               pos_q + skps_pkg::POS_W'(1) : skps_pkg::POS_W'(skps_pkg::SCAN_WINDOW);
    end
  end

  // result register
  always_comb begin
    out_vld_d  = out_vld_q & out_stall_i;
    out_prof_d = out_prof_q;
    out_ver_d  = out_ver_q;
    out_feat_d = out_feat_q;
    if (pop_o && it.last) begin
      out_vld_d  = 1'b1;
      out_ver_d  = ver_d;
      out_feat_d = flag_fin;
      out_prof_d = (ver_d >= skps_pkg::VER_W'(skps_pkg::MODERN_MIN_VER)) &&
                   (it.compute || flag_fin);
    end
  end

  // scanner state, cleared after each source
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      prev_q    <= 1'b0;
      mprog_q   <= '0;
      phase_q   <= PH_SEARCH;
      ver_q     <= '0;
      run_q     <= '0;
      alive_q   <= ALL_WORDS;
      flag_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (pop_o && it.last) begin
        pos_q   <= '0;
        prev_q  <= 1'b0;
        mprog_q <= '0;
        phase_q <= PH_SEARCH;
        ver_q   <= '0;
        run_q   <= '0;
        alive_q <= ALL_WORDS;
        flag_q  <= 1'b0;
      end else if (pop_o) begin
        pos_q   <= pos_d;
        prev_q  <= prev_d;
        mprog_q <= mprog_d;
        phase_q <= phase_d;
        ver_q   <= ver_d;
        run_q   <= run_d;
        alive_q <= alive_d;
        flag_q  <= flag_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_prof_q <= out_prof_d;
    out_ver_q  <= out_ver_d;
    out_feat_q <= out_feat_d;
  end

  assign out_valid_o    = out_vld_q;
  assign profile_o      = out_prof_q;
  assign glsl_version_o = out_ver_q;
  assign feature_seen_o = out_feat_q;

endmodule

`default_nettype wire

// ===== rtl/skps_checker.sv =====
// skps_checker: port level checks of the keyword scanner, bound to the top
// depends on skps_pkg and shader_profile_keyword_scanner_unit
`timescale 1ns / 1ps
`default_nettype none

module skps_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic                      profile_o,
  input wire logic [skps_pkg::VER_W-1:0] glsl_version_o,
  input wire logic                      feature_seen_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(profile_o) && $stable(glsl_version_o) && $stable(feature_seen_o))
    else $error("result changed while stalled");

  // modern strict needs a recent enough version
  a_modern_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && profile_o |->
      glsl_version_o >= skps_pkg::VER_W'(skps_pkg::MODERN_MIN_VER))
    else $error("modern profile with low version");

  // parse stops right after passing the limit
  a_version_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      glsl_version_o <= skps_pkg::VER_W'(skps_pkg::VERSION_LIMIT * 10 + 9))
    else $error("version out of range");

endmodule

bind shader_profile_keyword_scanner_unit skps_checker u_skps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .profile_o      (profile_o),
  .glsl_version_o (glsl_version_o),
  .feature_seen_o (feature_seen_o)
);

`default_nettype wire
